>>> rtl/core/histogram_gaussian_fit_assert.svh
// ----------------------------------------------------------------------------
// Histogram fit assertion macros
// Shared property forms for the checks at the end of the histogram fit block.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_GAUSSIAN_FIT_ASSERT_SVH
`define HISTOGRAM_GAUSSIAN_FIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HGF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram fit check failed");

// The consequent must hold in the cycle after the antecedent.
`define HGF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram fit check failed");

`endif

>>> rtl/core/hgf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram fit package
// Beat types, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package hgf_pkg;

   localparam int DEFAULT_NUM_BINS = 21;
   localparam int VAL_W = 17;
   localparam int WID_W = 16;
   localparam int CNT_W = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;
   localparam logic [VAL_W-1:0] OUT_MAX = 17'h1FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH = 2'd1;

   localparam logic [VAL_W-1:0] BIN_START_RESET = 17'd52429;
   localparam logic [WID_W-1:0] BIN_WIDTH_RESET = 16'd655;

   typedef struct packed {
      logic [VAL_W-1:0] intensity;
      logic             last_item;
   } hgf_req_type;

   typedef struct packed {
      logic [VAL_W-1:0] mean_value;
      logic [VAL_W-1:0] std_dev;
      logic [VAL_W-1:0] binned_count;
      logic             empty_set;
   } hgf_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BIN,
      S_SUM_MUL,
      S_SUM_ACC,
      S_DIV_MEAN,
      S_DEV_DIFF,
      S_DEV_SQ,
      S_DEV_LO,
      S_DEV_HI,
      S_DEV_ACC,
      S_DIV_VAR,
      S_SQRT,
      S_DONE
   } hgf_state_type;

endpackage

>>> rtl/core/histogram_gaussian_fit.sv
`timescale 1ns / 1ps
// Binning: after its accept beat an item walks the bins in order, one bin per cycle, until it
// hits one or passes the last. A last item then runs the fit: the weighted sums, the mean divide,
// the deviation sums, the variance divide and the integer square root, in that order.
// One item in flight: req_ready is high only in idle; one shared multiplier and divider serve the fit.
// Reset: synchronous, clears the bins, the sequencer and the result beat, and loads the
// default bin start (0.80) and bin width (0.01).
// ----------------------------------------------------------------------------
// Histogram mean and standard deviation
// Bins a stream of Q1.16 intensities and, on the last beat of a set, emits the
// count-weighted mean of the bin lower edges, the deviation and the count.
// ----------------------------------------------------------------------------
`include "histogram_gaussian_fit_assert.svh"

module histogram_gaussian_fit
   import hgf_pkg::*;
#(
   parameter int NUM_BINS = DEFAULT_NUM_BINS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hgf_req_type          req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hgf_rsp_type          rsp_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [VAL_W-1:0]     csr_wdata
);

   // Bin index width and the width that holds the largest edge, start + NUM_BINS*width.
   localparam int IDX_W  = $clog2(NUM_BINS);
   localparam int EDGE_W = WID_W + $clog2(NUM_BINS + 2);
   // The count total, the product width of the shared multiplier and the accumulator,
   // which holds the sum of count times squared distance over all bins.
   localparam int N_W    = CNT_W + $clog2(NUM_BINS);
   localparam int PROD_W = 2 * EDGE_W;
   localparam int SUM_W  = PROD_W + CNT_W + $clog2(NUM_BINS);
   localparam int SQ_W   = SUM_W + (SUM_W % 2);
   localparam int STEP_W = $clog2(SUM_W + 1);

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BINS - 1);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQ_W / 2 - 1);

   hgf_state_type state_ff, state_in;

   // Configuration registers.
   logic [VAL_W-1:0] bin_start_ff, bin_start_in;
   logic [WID_W-1:0] bin_width_ff, bin_width_in;

   // Histogram counters, one per bin.
   logic [CNT_W-1:0] cnt_ff [NUM_BINS];
   logic [CNT_W-1:0] cnt_in [NUM_BINS];

   logic rsp_valid_ff, rsp_valid_in;
   hgf_rsp_type rsp_data_ff, rsp_data_in;

   // Datapath registers of the sequencer.
   logic [VAL_W-1:0]  x_ff, x_in;
   logic              last_ff, last_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [EDGE_W-1:0] edge_ff, edge_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [EDGE_W-1:0] mu_ff, mu_in;
   logic [EDGE_W-1:0] d_ff, d_in;
   logic [PROD_W-1:0] dd_ff, dd_in;
   logic [PROD_W-1:0] mul_ff;
   logic [SUM_W-1:0]  num_ff, num_in;
   logic [N_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SQ_W-1:0]   sq_v_ff, sq_v_in;
   logic [SQ_W-1:0]   sq_res_ff, sq_res_in;
   logic [SQ_W-1:0]   sq_bit_ff, sq_bit_in;
   logic              empty_ff, empty_in;

   // Shared multiplier operands; the product is registered every cycle.
   logic [EDGE_W-1:0] mul_a, mul_b;

   // Combinational helpers.
   logic [EDGE_W-1:0] edge_next;
   logic [CNT_W-1:0]  cnt_sel;
   logic              bin_hit;
   logic [N_W:0]      div_trial;
   logic              div_ge;
   logic [N_W-1:0]    div_rem;
   logic [SUM_W-1:0]  div_num;
   logic [SQ_W-1:0]   sq_trial;
   logic              hold_free;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Edges are walked by repeated addition of the bin width.
   assign edge_next = edge_ff + EDGE_W'(bin_width_ff);
   assign cnt_sel   = cnt_ff[idx_ff];
   assign bin_hit   = (EDGE_W'(x_ff) <= edge_next);

   // One restoring divide step: the partial remainder always stays below the count.
   assign div_trial = {rem_ff, num_ff[SUM_W-1]};
   assign div_ge    = (div_trial >= {1'b0, n_ff});
   assign div_rem   = div_ge ? N_W'(div_trial - {1'b0, n_ff}) : div_trial[N_W-1:0];
   assign div_num   = {num_ff[SUM_W-2:0], div_ge};

   // One digit of the integer square root.
   assign sq_trial  = sq_res_ff + sq_bit_ff;

   assign hold_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_start_in = bin_start_ff;
      bin_width_in = bin_width_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      edge_in      = edge_ff;
      acc_in       = acc_ff;
      n_in         = n_ff;
      mu_in        = mu_ff;
      d_in         = d_ff;
      dd_in        = dd_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      empty_in     = empty_ff;
      mul_a        = '0;
      mul_b        = '0;

      if (csr_we) begin
         unique case (csr_idx)
            CSR_BIN_START: bin_start_in = csr_wdata;
            CSR_BIN_WIDTH: bin_width_in = csr_wdata[WID_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_payload.intensity;
               last_in  = req_payload.last_item;
               idx_in   = '0;
               edge_in  = EDGE_W'(bin_start_ff);
               state_in = S_BIN;
            end
         end
         S_BIN: begin
            // Values above the last upper edge fall through and are dropped.
            if (bin_hit || idx_ff == LAST_IDX) begin
               if (bin_hit && cnt_sel < CNT_MAX) begin
                  cnt_in[idx_ff] = cnt_sel + 1'b1;
               end
               idx_in   = '0;
               edge_in  = EDGE_W'(bin_start_ff);
               acc_in   = '0;
               n_in     = '0;
               state_in = last_ff ? S_SUM_MUL : S_IDLE;
            end else begin
               idx_in  = idx_ff + 1'b1;
               edge_in = edge_next;
            end
         end
         S_SUM_MUL: begin
            mul_a    = edge_ff;
            mul_b    = EDGE_W'(cnt_sel);
            state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            acc_in = acc_ff + SUM_W'(mul_ff);
            n_in   = n_ff + N_W'(cnt_sel);
            if (idx_ff == LAST_IDX) begin
               num_in   = acc_ff + SUM_W'(mul_ff);
               rem_in   = '0;
               step_in  = '0;
               state_in = S_DIV_MEAN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               edge_in  = edge_next;
               state_in = S_SUM_MUL;
            end
         end
         S_DIV_MEAN: begin
            if (n_ff == '0) begin
               empty_in = 1'b1;
               state_in = S_DONE;
            end else begin
               empty_in = 1'b0;
               num_in   = div_num;
               rem_in   = div_rem;
               step_in  = step_ff + 1'b1;
               if (step_ff == DIV_LAST) begin
                  mu_in    = div_num[EDGE_W-1:0];
                  idx_in   = '0;
                  edge_in  = EDGE_W'(bin_start_ff);
                  acc_in   = '0;
                  state_in = S_DEV_DIFF;
               end
            end
         end
         S_DEV_DIFF: begin
            d_in     = (edge_ff >= mu_ff) ? edge_ff - mu_ff : mu_ff - edge_ff;
            state_in = S_DEV_SQ;
         end
         S_DEV_SQ: begin
            mul_a    = d_ff;
            mul_b    = d_ff;
            state_in = S_DEV_LO;
         end
         S_DEV_LO: begin
            // The square is split in two halves so each product stays narrow.
            dd_in    = mul_ff;
            mul_a    = EDGE_W'(cnt_sel);
            mul_b    = mul_ff[EDGE_W-1:0];
            state_in = S_DEV_HI;
         end
         S_DEV_HI: begin
            mul_a    = EDGE_W'(cnt_sel);
            mul_b    = dd_ff[PROD_W-1:EDGE_W];
            acc_in   = acc_ff + SUM_W'(mul_ff);
            state_in = S_DEV_ACC;
         end
         S_DEV_ACC: begin
            acc_in = acc_ff + (SUM_W'(mul_ff) << EDGE_W);
            if (idx_ff == LAST_IDX) begin
               num_in   = acc_ff + (SUM_W'(mul_ff) << EDGE_W);
               rem_in   = '0;
               step_in  = '0;
               state_in = S_DIV_VAR;
            end else begin
               idx_in   = idx_ff + 1'b1;
               edge_in  = edge_next;
               state_in = S_DEV_DIFF;
            end
         end
         S_DIV_VAR: begin
            num_in  = div_num;
            rem_in  = div_rem;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               sq_v_in   = SQ_W'(div_num);
               sq_res_in = '0;
               sq_bit_in = SQ_W'(1) << (SQ_W - 2);
               step_in   = '0;
               state_in  = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sq_v_ff >= sq_trial) begin
               sq_v_in   = sq_v_ff - sq_trial;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            step_in   = step_ff + 1'b1;
            if (step_ff == SQRT_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // The result waits here until the output register is free, then the
            // bins are cleared for the next set.
            if (hold_free) begin
               if (empty_ff) begin
                  rsp_data_in = '{mean_value: '0, std_dev: '0, binned_count: '0,
                                  empty_set: 1'b1};
               end else begin
                  rsp_data_in.mean_value   = (mu_ff > EDGE_W'(OUT_MAX)) ?
                                             OUT_MAX : mu_ff[VAL_W-1:0];
                  rsp_data_in.std_dev      = (sq_res_ff > SQ_W'(OUT_MAX)) ?
                                             OUT_MAX : sq_res_ff[VAL_W-1:0];
                  rsp_data_in.binned_count = (n_ff > N_W'(OUT_MAX)) ?
                                             OUT_MAX : n_ff[VAL_W-1:0];
                  rsp_data_in.empty_set    = 1'b0;
               end
               rsp_valid_in = 1'b1;
               for (int b = 0; b < NUM_BINS; b++) begin
                  cnt_in[b] = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_start_ff <= BIN_START_RESET;
         bin_width_ff <= BIN_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BINS; b++) begin
            cnt_ff[b] <= '0;
         end
      end else begin
         bin_start_ff <= bin_start_in;
         bin_width_ff <= bin_width_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      x_ff        <= x_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      edge_ff     <= edge_in;
      acc_ff      <= acc_in;
      n_ff        <= n_in;
      mu_ff       <= mu_in;
      d_ff        <= d_in;
      dd_ff       <= dd_in;
      mul_ff      <= mul_a * mul_b;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      empty_ff    <= empty_in;
   end

   // A result beat only ever appears straight out of the final sequencer state.
   `HGF_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DONE)
   // An empty set carries all-zero figures.
   `HGF_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid_ff && rsp_data_ff.empty_set, rsp_data_ff.mean_value == '0 && rsp_data_ff.std_dev == '0 && rsp_data_ff.binned_count == '0)
   // The first bin is clear and the sequencer is idle once a result has been issued.
   `HGF_ASSERT_NEXT(a_bins_cleared, clock, reset, state_ff == S_DONE && hold_free, cnt_ff[0] == '0 && state_ff == S_IDLE)

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram fit testbench
// Drives sets of Q1.16 intensities into the histogram fit block, predicts the
// mean, deviation and count of every set and checks each result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import hgf_pkg::*;

   localparam int NBINS = DEFAULT_NUM_BINS;
   localparam int RANDOM_ITEMS = 1620;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   // A register index that names no register.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hgf_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hgf_rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = CSR_BIN_START;
   logic [VAL_W-1:0] csr_wdata = '0;

   // Predictor state: its own copy of the bin edges and the bin counters.
   logic [VAL_W-1:0] edge_lo;
   logic [WID_W-1:0] edge_step;
   logic [CNT_W-1:0] hist [NBINS];

   hgf_rsp_type fit_queue[$];
   int fail_count = 0;
   int fit_count = 0;
   int empty_count = 0;
   int quiet_cycles = 0;
   bit stim_done = 1'b0;

   // Directed rows. A row with check set also carries a result typed in by hand,
   // which is compared with the predictor's own answer.
   typedef struct {
      logic [VAL_W-1:0] intensity;
      logic             last_item;
      bit               check;
      hgf_rsp_type      fit;
   } stim_row_type;

   histogram_gaussian_fit i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload, .csr_we, .csr_idx, .csr_wdata
   );

   always #5 clock = ~clock;

   task automatic report(input string what);
      fail_count++;
      $display("tb: mismatch %0d: %s", fail_count, what);
   endtask

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] clip(input longint unsigned v);
      return (v > OUT_MAX) ? OUT_MAX : v[VAL_W-1:0];
   endfunction

   // Bins one intensity and, on the last beat, works out the fit and clears the
   // bins. Returns 1 when a result beat is due.
   function automatic bit bin_and_fit(input hgf_req_type it, output hgf_rsp_type fit);
      longint unsigned n = 0, wsum = 0, mu, q = 0, r = 0, lo, d, p, upper;
      fit = '0;
      for (int i = 0; i < NBINS; i++) begin
         upper = longint'(edge_lo) + longint'(i + 1) * longint'(edge_step);
         if (it.intensity <= upper) begin
            if (hist[i] != CNT_MAX) hist[i]++;
            break;
         end
      end
      if (!it.last_item) return 1'b0;
      for (int i = 0; i < NBINS; i++) begin
         lo = longint'(edge_lo) + longint'(i) * longint'(edge_step);
         n += hist[i];
         wsum += lo * hist[i];
      end
      if (n == 0) begin
         fit.empty_set = 1'b1;
      end else begin
         mu = wsum / n;
         // Exact floor of the weighted squared sum over n, kept as quotient and remainder.
         for (int i = 0; i < NBINS; i++) begin
            lo = longint'(edge_lo) + longint'(i) * longint'(edge_step);
            d = (lo > mu) ? lo - mu : mu - lo;
            p = longint'(hist[i]) * (d * d);
            q += p / n;
            r += p % n;
            if (r >= n) begin
               r -= n;
               q++;
            end
         end
         fit.mean_value = clip(mu);
         fit.std_dev = clip(root_floor(q));
         fit.binned_count = clip(n);
      end
      foreach (hist[i]) hist[i] = '0;
      return 1'b1;
   endfunction

   // Register write one cycle on; the block is idle whenever this is called.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BIN_START) edge_lo = val;
      else if (idx == CSR_BIN_WIDTH) edge_step = val[WID_W-1:0];
   endtask

   function automatic int gap_length();
      int sel = $urandom_range(0, 99);
      if (sel < 40) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Presents one beat and holds it until accepted, then records the prediction.
   // Valid stays high after the accept so that a following beat can go straight
   // out; whoever stops sending drops it.
   task automatic send_beat(input hgf_req_type it, input bit use_gaps);
      hgf_rsp_type fit;
      int gap;
      gap = use_gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (bin_and_fit(it, fit)) fit_queue.insert(fit_queue.size(), fit);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (fit_queue.size() != 0) @(negedge clock);
      // A non-last beat may still be binning after the last result arrived.
      repeat (NBINS + 4) @(negedge clock);
   endtask

   // One set of random content: mostly near the bins, sometimes anywhere.
   task automatic random_set(input int len, input bit use_gaps);
      hgf_req_type it;
      longint unsigned span;
      for (int k = 0; k < len; k++) begin
         span = longint'(edge_step) * (NBINS + 2);
         if ($urandom_range(0, 9) < 7 && span < 131071)
            it.intensity = clip(longint'(edge_lo) - edge_step
                                + $urandom_range(0, int'(span)));
         else
            it.intensity = VAL_W'($urandom_range(0, 131071));
         it.last_item = (k == len - 1);
         send_beat(it, use_gaps);
      end
   endtask

   // Result side: random stalls, then a compare with the oldest expectation.
   initial begin
      hgf_rsp_type exp_fit;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 9) < 7);
         end
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (fit_queue.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               exp_fit = fit_queue.pop_front();
               fit_count++;
               if (exp_fit.empty_set) empty_count++;
               if (rsp_payload.mean_value !== exp_fit.mean_value)
                  report($sformatf("mean %0d, expected %0d",
                                   rsp_payload.mean_value, exp_fit.mean_value));
               if (rsp_payload.std_dev !== exp_fit.std_dev)
                  report($sformatf("deviation %0d, expected %0d",
                                   rsp_payload.std_dev, exp_fit.std_dev));
               if (rsp_payload.binned_count !== exp_fit.binned_count)
                  report($sformatf("count %0d, expected %0d",
                                   rsp_payload.binned_count, exp_fit.binned_count));
               if (rsp_payload.empty_set !== exp_fit.empty_set)
                  report($sformatf("empty flag %0b, expected %0b",
                                   rsp_payload.empty_set, exp_fit.empty_set));
            end
         end
         @(negedge clock);
      end
   end

   // Watchdog: counts cycles in which neither channel moves a beat, until the stimulus is done.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: timeout with %0d results outstanding", fit_queue.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      // Directed part at the reset edges: bin 0 lower edge is 52429, width 655.
      stim_row_type rows [11] = '{
         '{17'd66185, 1'b1, 1'b1, '{0, 0, 0, 1'b1}},         // nothing binned
         '{17'd0, 1'b1, 1'b1, '{52429, 0, 1, 1'b0}},         // below first edge
         '{17'h1FFFF, 1'b1, 1'b1, '{0, 0, 0, 1'b1}},         // above last edge
         '{17'd52429, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},
         '{17'd53084, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},         // exactly on an edge
         '{17'd53085, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},
         '{17'd66184, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},         // last upper edge
         '{17'd66185, 1'b1, 1'b0, '{0, 0, 0, 1'b0}},
         '{17'h10000, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},
         '{17'h0AAAA, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},
         '{17'h15555, 1'b1, 1'b0, '{0, 0, 0, 1'b0}}
      };
      hgf_rsp_type pred;
      hgf_req_type it;
      int items = 0;
      int len;

      edge_lo = BIN_START_RESET;
      edge_step = BIN_WIDTH_RESET;
      foreach (hist[i]) hist[i] = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         it.intensity = rows[r].intensity;
         it.last_item = rows[r].last_item;
         send_beat(it, 1'b0);
         items++;
         if (rows[r].check && fit_queue[$] != rows[r].fit)
            report($sformatf("directed row %0d disagrees with the typed result", r));
      end
      wait_drained();

      // Zero width: every edge collapses onto bin_start.
      write_reg(CSR_BIN_WIDTH, '0);
      write_reg(CSR_BIN_START, 17'd40000);
      random_set(6, 1'b1);
      items += 6;
      wait_drained();

      // Widest bins at the largest start: every item lands in bin 0 and the mean sits at the top.
      write_reg(CSR_BIN_WIDTH, 17'hFFFF);
      write_reg(CSR_BIN_START, 17'h1FFFF);
      random_set(8, 1'b1);
      items += 8;
      wait_drained();

      // Random phases, each under a fresh register setting.
      while (items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: write_reg(CSR_BIN_START, VAL_W'($urandom_range(0, 131071)));
            1: write_reg(CSR_BIN_WIDTH, VAL_W'($urandom_range(1, 8000)));
            2: write_reg(CSR_BIN_WIDTH, VAL_W'($urandom_range(1, 65535)));
            default: write_reg(CSR_BIN_START, VAL_W'($urandom_range(40000, 70000)));
         endcase
         // An out-of-range index must leave both registers untouched.
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_UNUSED_IDX, VAL_W'($urandom_range(0, 131071)));
         for (int s = 0; s < 6; s++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 20);
            random_set(len, ($urandom_range(0, 3) != 0));
            items += len;
         end
         wait_drained();
      end

      write_reg(CSR_BIN_START, BIN_START_RESET);
      write_reg(CSR_BIN_WIDTH, BIN_WIDTH_RESET);
      random_set(30, 1'b1);
      items += 30;
      req_valid <= 1'b0;

      stim_done = 1'b1;
      for (int c = 0; c < STALL_LIMIT && fit_queue.size() != 0; c++) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fit_queue.size() != 0)
         report($sformatf("%0d results never arrived", fit_queue.size()));

      $display("tb: %0d intensities sent, %0d fits checked (%0d of empty sets)",
               items, fit_count, empty_count);
      $display("tb: bin widths from zero to full scale, starts from low to saturated");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/hgf_pkg.sv
rtl/core/histogram_gaussian_fit.sv
test/tb_top.sv
